>>> rtl/sbd_pkg.sv
// Shared types and constants for the system bus decoder with work RAM port.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sbd_pkg;

    // Largest work RAM index width and the default configured width
    localparam int RAM_IDX_W         = 17;
    localparam int RAM_ADDR_BITS_DEF = 17;
    localparam int PORT_ADDR_W       = 17;

    // Bank codes
    localparam logic [7:0] BANK_WRAM_LO = 8'h7E;
    localparam logic [7:0] BANK_WRAM_HI = 8'h7F;
    localparam logic [7:0] BANK_CART_LO = 8'h40;

    // System area offsets
    localparam logic [15:0] OFF_CART_BASE  = 16'h6000;
    localparam logic [15:0] OFF_MIRROR_END = 16'h2000;
    localparam logic [15:0] OFF_VIDEO_LO   = 16'h2100;
    localparam logic [15:0] OFF_VIDEO_HI   = 16'h213F;
    localparam logic [15:0] OFF_VIDEO_X    = 16'h4200;
    localparam logic [15:0] OFF_AUDIO_LO   = 16'h2140;
    localparam logic [15:0] OFF_AUDIO_HI   = 16'h217F;
    localparam logic [15:0] OFF_PORT_DATA  = 16'h2180;
    localparam logic [15:0] OFF_PORT_LO    = 16'h2181;
    localparam logic [15:0] OFF_PORT_MID   = 16'h2182;
    localparam logic [15:0] OFF_PORT_HI    = 16'h2183;
    localparam logic [15:0] OFF_DMA_LO     = 16'h4300;
    localparam logic [15:0] OFF_DMA_HI     = 16'h437F;
    localparam logic [15:0] OFF_DMA_EN0    = 16'h420B;
    localparam logic [15:0] OFF_DMA_EN1    = 16'h420C;

    typedef enum logic [2:0] {
        TGT_IGNORED  = 3'd0,
        TGT_RAM      = 3'd1,
        TGT_CART     = 3'd2,
        TGT_VIDEO    = 3'd3,
        TGT_AUDIO    = 3'd4,
        TGT_DMA      = 3'd5,
        TGT_PORT     = 3'd6,
        TGT_UNMAPPED = 3'd7
    } t_target;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RAM,
        OP_PORT_DATA,
        OP_PORT_LO,
        OP_PORT_MID,
        OP_PORT_HI
    } t_op;

    // Classified request handed from the front to the back
    typedef struct packed {
        t_op                   op;
        t_target               target;
        logic                  wr;
        logic                  latch_en;
        logic [7:0]            wdata;
        logic [RAM_IDX_W-1:0]  ram_idx;
        logic [23:0]           dev_addr;
    } t_req;

endpackage

`default_nettype wire

>>> rtl/sbd_decode.sv
// Front decoder: classifies one bus request into target and operation.
// Depends on sbd_pkg.
`default_nettype none

module sbd_decode (
    input  wire logic         i_mode,
    input  wire logic [23:0]  i_address,
    input  wire logic [7:0]   i_write_data,
    input  wire logic         i_data_strobe,
    input  wire logic         i_program_strobe,
    input  wire logic         i_private_access,
    output sbd_pkg::t_req     o_req
);

    logic [7:0]  bank;
    logic [15:0] off;
    logic        ign;
    logic        hi_mask;

    assign bank    = i_address[23:16];
    assign off     = i_address[15:0];
    assign ign     = !i_private_access && !i_data_strobe && !i_program_strobe;
    // High port offset in any bank without bit 6 keeps bit 0 of the written byte
    assign hi_mask = i_mode && !bank[6] && (off == sbd_pkg::OFF_PORT_HI);

    // Decode bank and offset to one target
    always_comb begin
        o_req          = '0;
        o_req.op       = sbd_pkg::OP_NONE;
        o_req.target   = sbd_pkg::TGT_UNMAPPED;
        o_req.wr       = i_mode && !ign;
        o_req.latch_en = !i_private_access && !ign;
        o_req.wdata    = hi_mask ? {7'd0, i_write_data[0]} : i_write_data;
        o_req.ram_idx  = '0;
        o_req.dev_addr = '0;

        if (ign) begin
            o_req.target = sbd_pkg::TGT_IGNORED;
        end else if (bank == sbd_pkg::BANK_WRAM_LO || bank == sbd_pkg::BANK_WRAM_HI) begin
            o_req.target  = sbd_pkg::TGT_RAM;
            o_req.op      = sbd_pkg::OP_RAM;
            o_req.ram_idx = {bank[0], off};
        end else if (bank >= sbd_pkg::BANK_CART_LO) begin
            o_req.target = sbd_pkg::TGT_CART;
        end else if (off >= sbd_pkg::OFF_CART_BASE) begin
            o_req.target = sbd_pkg::TGT_CART;
        end else if (off < sbd_pkg::OFF_MIRROR_END) begin
            o_req.target  = sbd_pkg::TGT_RAM;
            o_req.op      = sbd_pkg::OP_RAM;
            o_req.ram_idx = {1'b0, off};
        end else if ((off >= sbd_pkg::OFF_VIDEO_LO && off <= sbd_pkg::OFF_VIDEO_HI)
                     || off == sbd_pkg::OFF_VIDEO_X) begin
            o_req.target = sbd_pkg::TGT_VIDEO;
        end else if (off >= sbd_pkg::OFF_AUDIO_LO && off <= sbd_pkg::OFF_AUDIO_HI) begin
            o_req.target = sbd_pkg::TGT_AUDIO;
        end else if (off == sbd_pkg::OFF_PORT_DATA) begin
            o_req.target = sbd_pkg::TGT_PORT;
            o_req.op     = sbd_pkg::OP_PORT_DATA;
        end else if (off == sbd_pkg::OFF_PORT_LO) begin
            o_req.target = sbd_pkg::TGT_PORT;
            o_req.op     = sbd_pkg::OP_PORT_LO;
        end else if (off == sbd_pkg::OFF_PORT_MID) begin
            o_req.target = sbd_pkg::TGT_PORT;
            o_req.op     = sbd_pkg::OP_PORT_MID;
        end else if (off == sbd_pkg::OFF_PORT_HI) begin
            o_req.target = sbd_pkg::TGT_PORT;
            o_req.op     = sbd_pkg::OP_PORT_HI;
        end else if ((off >= sbd_pkg::OFF_DMA_LO && off <= sbd_pkg::OFF_DMA_HI)
                     || off == sbd_pkg::OFF_DMA_EN0 || off == sbd_pkg::OFF_DMA_EN1) begin
            o_req.target = sbd_pkg::TGT_DMA;
        end else begin
            o_req.target = sbd_pkg::TGT_UNMAPPED;
        end

        // Forward the address to external devices only
        if (o_req.target == sbd_pkg::TGT_CART || o_req.target == sbd_pkg::TGT_VIDEO
            || o_req.target == sbd_pkg::TGT_AUDIO || o_req.target == sbd_pkg::TGT_DMA) begin
            o_req.dev_addr = i_address;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sbd_queue.sv
// Two-entry request queue between the decoder and the execution stage.
// Depends on sbd_pkg for the request type.
`default_nettype none

module sbd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sbd_pkg::t_req  i_req,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output sbd_pkg::t_req       o_req
);

    sbd_pkg::t_req r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic [1:0]    n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_req   = r_mem[r_rd_ptr];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Hold request payloads
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sbd_back.sv
// Execution stage: work RAM, port address, open-bus latch and result register.
// Depends on sbd_pkg.
`default_nettype none

module sbd_back #(
    parameter int RAM_ADDR_BITS = sbd_pkg::RAM_ADDR_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire sbd_pkg::t_req  i_req,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [2:0]          o_target,
    output logic [7:0]          o_read_data,
    output logic [23:0]         o_device_address,
    output logic [7:0]          o_device_write_data,
    output logic [7:0]          o_open_bus
);

    localparam int RAM_DEPTH = 1 << RAM_ADDR_BITS;

    logic [7:0]                       r_ram [RAM_DEPTH];
    logic [7:0]                       r_ram_q;
    logic [sbd_pkg::PORT_ADDR_W-1:0]  r_port_addr;
    logic [sbd_pkg::PORT_ADDR_W-1:0]  n_port_addr;
    logic [7:0]                       r_latch;
    logic [7:0]                       n_latch;
    logic                             r_latch_ram;
    logic                             n_latch_ram;

    logic                             r_out_valid;
    sbd_pkg::t_target                 r_out_target;
    logic [7:0]                       r_out_rdata;
    logic                             r_out_rd_ram;
    logic [23:0]                      r_out_dev_addr;
    logic [7:0]                       r_out_dwd;

    logic                             fire;
    logic                             ram_op;
    logic [RAM_ADDR_BITS-1:0]         ram_idx;
    logic [7:0]                       port_val;
    logic [7:0]                       latch_cur;

    assign fire      = i_req_valid && (!r_out_valid || i_ready);
    assign o_pop     = fire;
    assign ram_op    = (i_req.op == sbd_pkg::OP_RAM) || (i_req.op == sbd_pkg::OP_PORT_DATA);
    assign ram_idx   = (i_req.op == sbd_pkg::OP_PORT_DATA) ? r_port_addr[RAM_ADDR_BITS-1:0]
                                                           : i_req.ram_idx[RAM_ADDR_BITS-1:0];
    // Latch may still be pending on the last RAM read
    assign latch_cur = r_latch_ram ? r_ram_q : r_latch;

    // Select port register read value
    always_comb begin
        unique case (i_req.op)
            sbd_pkg::OP_PORT_LO:  port_val = r_port_addr[7:0];
            sbd_pkg::OP_PORT_MID: port_val = r_port_addr[15:8];
            sbd_pkg::OP_PORT_HI:  port_val = {7'd0, r_port_addr[16]};
            default:              port_val = 8'd0;
        endcase
    end

    // Next port address
    always_comb begin
        n_port_addr = r_port_addr;
        unique case (i_req.op)
            sbd_pkg::OP_PORT_DATA: n_port_addr = r_port_addr + 17'd1;
            sbd_pkg::OP_PORT_LO:   if (i_req.wr) n_port_addr[7:0] = i_req.wdata;
            sbd_pkg::OP_PORT_MID:  if (i_req.wr) n_port_addr[15:8] = i_req.wdata;
            sbd_pkg::OP_PORT_HI:   if (i_req.wr) n_port_addr[16] = i_req.wdata[0];
            default:               n_port_addr = r_port_addr;
        endcase
    end

    // Next open-bus latch
    always_comb begin
        n_latch     = latch_cur;
        n_latch_ram = 1'b0;
        if (i_req.latch_en) begin
            if (i_req.wr) begin
                n_latch = i_req.wdata;
            end else if (ram_op) begin
                n_latch_ram = 1'b1;
            end else begin
                n_latch = port_val;
            end
        end
    end

    // Work RAM: one write or one registered read per request
    always_ff @(posedge i_clk) begin
        if (fire && ram_op) begin
            if (i_req.wr) begin
                r_ram[ram_idx] <= i_req.wdata;
            end else begin
                r_ram_q <= r_ram[ram_idx];
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_port_addr <= '0;
            r_latch     <= 8'd0;
            r_latch_ram <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_port_addr <= n_port_addr;
                r_latch     <= n_latch;
                r_latch_ram <= n_latch_ram;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_target   <= i_req.target;
            r_out_rdata    <= i_req.wr ? 8'd0 : port_val;
            r_out_rd_ram   <= ram_op && !i_req.wr;
            r_out_dev_addr <= i_req.dev_addr;
            r_out_dwd      <= i_req.wr ? i_req.wdata : 8'd0;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_target            = r_out_target;
    assign o_read_data         = r_out_rd_ram ? r_ram_q : r_out_rdata;
    assign o_device_address    = r_out_dev_addr;
    assign o_device_write_data = r_out_dwd;
    assign o_open_bus          = r_latch_ram ? r_ram_q : r_latch;

endmodule

`default_nettype wire

>>> rtl/system_bus_decoder_wram_port.sv
// System bus decoder with work RAM and its indirect data port (top level).
// Depends on sbd_pkg, sbd_decode, sbd_queue and sbd_back.
//
// Usage: one bus request enters on the i_valid/o_ready channel (mode, 24-bit
// address, write byte, processor strobes, private DMA flag). Each request
// yields exactly one result on the o_valid/i_ready channel: target code,
// read byte, forwarded device address and write byte, and open-bus value.
// Requests are decoded as they arrive and wait in a two-entry queue; the
// execution stage serves work RAM, the port address and the open-bus latch.
// Each request is registered in the queue, then in the execution stage's
// result register. Throughput is one request per cycle while the receiver
// takes results, set by the single work RAM port (one read or write per
// cycle, read data registered). When the receiver stalls, the result holds
// and the queue takes up to two more requests before o_ready drops.
// Reset clears the port address, the open-bus latch and all valid state;
// work RAM contents are undefined until written and need no clearing.
`default_nettype none

module system_bus_decoder_wram_port #(
    parameter int RAM_ADDR_BITS = sbd_pkg::RAM_ADDR_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic         i_mode,
    input  wire logic [23:0]  i_address,
    input  wire logic [7:0]   i_write_data,
    input  wire logic         i_data_strobe,
    input  wire logic         i_program_strobe,
    input  wire logic         i_private_access,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [2:0]        o_target,
    output logic [7:0]        o_read_data,
    output logic [23:0]       o_device_address,
    output logic [7:0]        o_device_write_data,
    output logic [7:0]        o_open_bus
);

    sbd_pkg::t_req dec_req;
    sbd_pkg::t_req q_req;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;

    assign o_ready = !q_full;

    // Classify the incoming request
    sbd_decode u_decode (
        .i_mode           (i_mode),
        .i_address        (i_address),
        .i_write_data     (i_write_data),
        .i_data_strobe    (i_data_strobe),
        .i_program_strobe (i_program_strobe),
        .i_private_access (i_private_access),
        .o_req            (dec_req)
    );

    // Decouple front and back
    sbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_req   (dec_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    // Carry out the request
    sbd_back #(
        .RAM_ADDR_BITS (RAM_ADDR_BITS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_valid         (q_valid),
        .i_req               (q_req),
        .o_pop               (q_pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_target            (o_target),
        .o_read_data         (o_read_data),
        .o_device_address    (o_device_address),
        .o_device_write_data (o_device_write_data),
        .o_open_bus          (o_open_bus)
    );

endmodule

`default_nettype wire
